// File: rtl/salsa20_ctr_stream_cipher_defines.svh
// ----------------------------------------------------------------------------
// salsa20 ctr stream cipher assertion macros
// concurrent assertion helpers, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef SALSA20_CTR_STREAM_CIPHER_DEFINES_SVH
`define SALSA20_CTR_STREAM_CIPHER_DEFINES_SVH

// checked outside reset only
`define S20_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define S20_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/s20ctr_pkg.sv
// ----------------------------------------------------------------------------
// s20ctr_pkg
// types, constants and salsa20 round functions shared by the cipher modules
// ----------------------------------------------------------------------------
`default_nettype none

package s20ctr_pkg;

  localparam int unsigned RoundCountDef = 20;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned CfgIdxW       = 3;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    GEN_LOAD,
    GEN_ROUND,
    GEN_FINAL,
    GEN_READY
  } gen_state_e;

  typedef logic [15:0][31:0] st_t;
  typedef logic [7:0][63:0]  blk_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [2:0]  pos;
  } item_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic consume;
    logic restart;
  } ks_ctrl_t;

  typedef struct packed {
    logic ready;
    blk_t block;
  } ks_stat_t;

  function automatic logic [31:0] rotl(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic qr_t quarter(logic [31:0] a, logic [31:0] b,
                                  logic [31:0] c, logic [31:0] d);
    qr_t q;
    q.b = b ^ rotl(a + d, 7);
    q.c = c ^ rotl(q.b + a, 9);
    q.d = d ^ rotl(q.c + q.b, 13);
    q.a = a ^ rotl(q.d + q.c, 18);
    return q;
  endfunction

  // even rounds work on columns, odd rounds on rows
  function automatic st_t salsa_round(st_t x, logic odd);
    st_t y;
    qr_t q0;
    qr_t q1;
    qr_t q2;
    qr_t q3;
    y = x;
    if (!odd) begin
      q0 = quarter(x[0],  x[4],  x[8],  x[12]);
      q1 = quarter(x[5],  x[9],  x[13], x[1]);
      q2 = quarter(x[10], x[14], x[2],  x[6]);
      q3 = quarter(x[15], x[3],  x[7],  x[11]);
      y[0]  = q0.a; y[4]  = q0.b; y[8]  = q0.c; y[12] = q0.d;
      y[5]  = q1.a; y[9]  = q1.b; y[13] = q1.c; y[1]  = q1.d;
      y[10] = q2.a; y[14] = q2.b; y[2]  = q2.c; y[6]  = q2.d;
      y[15] = q3.a; y[3]  = q3.b; y[7]  = q3.c; y[11] = q3.d;
    end else begin
      q0 = quarter(x[0],  x[1],  x[2],  x[3]);
      q1 = quarter(x[5],  x[6],  x[7],  x[4]);
      q2 = quarter(x[10], x[11], x[8],  x[9]);
      q3 = quarter(x[15], x[12], x[13], x[14]);
      y[0]  = q0.a; y[1]  = q0.b; y[2]  = q0.c; y[3]  = q0.d;
      y[5]  = q1.a; y[6]  = q1.b; y[7]  = q1.c; y[4]  = q1.d;
      y[10] = q2.a; y[11] = q2.b; y[8]  = q2.c; y[9]  = q2.d;
      y[15] = q3.a; y[12] = q3.b; y[13] = q3.c; y[14] = q3.d;
    end
    return y;
  endfunction

  function automatic st_t init_state(logic [63:0] k0, logic [63:0] k1,
                                     logic [63:0] k2, logic [63:0] k3,
                                     logic [63:0] n, logic [63:0] ctr);
    st_t s;
    s[0]  = Sigma0;
    s[1]  = k0[31:0];
    s[2]  = k0[63:32];
    s[3]  = k1[31:0];
    s[4]  = k1[63:32];
    s[5]  = Sigma1;
    s[6]  = n[31:0];
    s[7]  = n[63:32];
    s[8]  = ctr[31:0];
    s[9]  = ctr[63:32];
    s[10] = Sigma2;
    s[11] = k2[31:0];
    s[12] = k2[63:32];
    s[13] = k3[31:0];
    s[14] = k3[63:32];
    s[15] = Sigma3;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/s20ctr_fifo.sv
// ----------------------------------------------------------------------------
// s20ctr_fifo
// small first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
`default_nettype none

module s20ctr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push_ok;
  logic             pop_ok;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign push_ok   = push_i && !full_o;
  assign pop_ok    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/s20ctr_front.sv
// ----------------------------------------------------------------------------
// s20ctr_front
// input side: tags each item with its keystream word position and queues it
// ----------------------------------------------------------------------------
`default_nettype none

module s20ctr_front import s20ctr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [63:0] data_in_i,
  input  wire logic [3:0]  byte_count_i,
  input  wire logic        last_item_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output item_t            item_o,
  output logic             empty_o
);

  logic [2:0] pos_q, pos_d;
  logic       accept;
  item_t      item_in;

  assign accept = push_i && !full_o;

  always_comb begin
    item_in.data  = data_in_i;
    item_in.count = byte_count_i;
    item_in.last  = last_item_i;
    item_in.pos   = pos_q;
    pos_d         = pos_q;
    if (accept) begin
      pos_d = last_item_i ? '0 : pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  s20ctr_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QueueDepth)
  ) u_in_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .wr_data_i (item_in),
    .full_o    (full_o),
    .pop_i     (pop_i),
    .rd_data_o (item_o),
    .empty_o   (empty_o)
  );

endmodule

`default_nettype wire

// File: rtl/s20ctr_core.sv
// ----------------------------------------------------------------------------
// s20ctr_core
// key and nonce registers, block counter and iterated salsa20 round unit
// ----------------------------------------------------------------------------
`default_nettype none

module s20ctr_core import s20ctr_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire ks_ctrl_t           ctrl_i,
  output ks_stat_t                stat_o
);

  localparam int unsigned RndW = $clog2(ROUND_COUNT);

  gen_state_e      state_q, state_d;
  st_t             w_q, w_d;
  st_t             init;
  logic [63:0]     ctr_q, ctr_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic [63:0]     key0_q, key1_q, key2_q, key3_q, nonce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_KEY0:  key0_q  <= cfg_data_i;
        REG_KEY1:  key1_q  <= cfg_data_i;
        REG_KEY2:  key2_q  <= cfg_data_i;
        REG_KEY3:  key3_q  <= cfg_data_i;
        REG_NONCE: nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign init = init_state(key0_q, key1_q, key2_q, key3_q, nonce_q, ctr_q);

  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    ctr_d   = ctr_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      GEN_LOAD: begin
        w_d     = init;
        rnd_d   = '0;
        state_d = GEN_ROUND;
      end
      GEN_ROUND: begin
        w_d   = salsa_round(w_q, rnd_q[0]);
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RndW'(ROUND_COUNT - 1)) begin
          state_d = GEN_FINAL;
        end
      end
      GEN_FINAL: begin
        for (int i = 0; i < 16; i++) begin
          w_d[i] = w_q[i] + init[i];
        end
        state_d = GEN_READY;
      end
      GEN_READY: ;
      default: state_d = GEN_LOAD;
    endcase
    // end of message sends the counter home, a taken block starts the next, a config write reloads
    if (ctrl_i.restart) begin
      ctr_d   = '0;
      state_d = GEN_LOAD;
    end else if (ctrl_i.consume) begin
      ctr_d   = ctr_q + 1'b1;
      state_d = GEN_LOAD;
    end else if (cfg_we_i) begin
      state_d = GEN_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_LOAD;
      ctr_q   <= '0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign stat_o.ready = (state_q == GEN_READY);
  assign stat_o.block = w_q;

endmodule

`default_nettype wire

// File: rtl/s20ctr_back.sv
// ----------------------------------------------------------------------------
// s20ctr_back
// output side: xors queued items with keystream, masks bytes, queues results
// ----------------------------------------------------------------------------
`default_nettype none

module s20ctr_back import s20ctr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire item_t    item_i,
  input  wire logic     in_empty_i,
  output logic          in_pop_o,
  input  wire ks_stat_t stat_i,
  output ks_ctrl_t      ctrl_o,
  input  wire logic     pop_i,
  output res_t          res_o,
  output logic          empty_o
);

  blk_t        act_q;
  logic        first;
  logic        go;
  logic        out_full;
  logic [63:0] ks;
  logic [63:0] mask;
  res_t        res_in;

  assign first = (item_i.pos == '0);
  assign go    = !in_empty_i && !out_full && (!first || stat_i.ready);
  assign ks    = first ? stat_i.block[0] : act_q[item_i.pos];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{item_i.count > 4'(i)}};
    end
    res_in.data  = (item_i.data ^ ks) & mask;
    res_in.count = item_i.count;
    res_in.last  = item_i.last;
  end

  assign in_pop_o       = go;
  assign ctrl_o.consume = go && first;
  assign ctrl_o.restart = go && item_i.last;

  always_ff @(posedge clk_i) begin
    if (go && first) begin
      act_q <= stat_i.block;
    end
  end

  s20ctr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QueueDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (go),
    .wr_data_i (res_in),
    .full_o    (out_full),
    .pop_i     (pop_i),
    .rd_data_o (res_o),
    .empty_o   (empty_o)
  );

endmodule

`default_nettype wire

// File: rtl/salsa20_ctr_stream_cipher.sv
// a result shows in the cycle after its item is taken, once its block is ready
// a word at block position zero waits for the round unit to load, run its rounds and add the input
// each block serves eight words; the word rate is set by the one-round-per-cycle unit
// the next block is computed while the current one is in use; last word restarts at zero
// reset: asynchronous, queues empty, counter and position zero, key and nonce zero
// ----------------------------------------------------------------------------
// salsa20_ctr_stream_cipher
// salsa20 counter mode cipher on 64-bit words, queue handshake on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_ctr_stream_cipher import s20ctr_pkg::*; #(
  parameter int unsigned ROUND_COUNT = RoundCountDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               push,
  input  wire logic [63:0]        data_in_i,
  input  wire logic [3:0]         byte_count_i,
  input  wire logic               last_item_i,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output logic [63:0]             data_out_o,
  output logic [3:0]              byte_count_out_o,
  output logic                    last_out_o
);

  item_t    item;
  logic     item_empty;
  logic     item_pop;
  ks_ctrl_t ctrl;
  ks_stat_t stat;
  res_t     res;

  assign cfg_ready_o = 1'b1;

  s20ctr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_in_i    (data_in_i),
    .byte_count_i (byte_count_i),
    .last_item_i  (last_item_i),
    .full_o       (full),
    .pop_i        (item_pop),
    .item_o       (item),
    .empty_o      (item_empty)
  );

  s20ctr_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

  s20ctr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .in_empty_i (item_empty),
    .in_pop_o   (item_pop),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .pop_i      (pop),
    .res_o      (res),
    .empty_o    (empty)
  );

  assign data_out_o       = res.data;
  assign byte_count_out_o = res.count;
  assign last_out_o       = res.last;

endmodule

`default_nettype wire

// File: rtl/s20ctr_chk.sv
// ----------------------------------------------------------------------------
// s20ctr_chk
// port-level checks on the cipher, attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "salsa20_ctr_stream_cipher_defines.svh"

module s20ctr_chk import s20ctr_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic [CfgIdxW-1:0] cfg_index_i,
  input wire logic [63:0]        cfg_data_i,
  input wire logic               push,
  input wire logic [63:0]        data_in_i,
  input wire logic [3:0]         byte_count_i,
  input wire logic               last_item_i,
  input wire logic               full,
  input wire logic               pop,
  input wire logic               empty,
  input wire logic [63:0]        data_out_o,
  input wire logic [3:0]         byte_count_out_o,
  input wire logic               last_out_o
);

  logic [4:0]  inflight_q, inflight_d;
  logic [63:0] mask;
  logic        in_acc;
  logic        out_acc;
  logic        unused;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;
  assign unused  = ^{cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i,
                     data_in_i, byte_count_i, last_item_i, last_out_o};

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 1'b1;
    end
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{byte_count_out_o > 4'(i)}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `S20_ASSERT_RST(a_reset_empty, !rst_ni |=> (empty && !full), "queues not empty in reset")
  `S20_ASSERT(a_no_phantom, !empty |-> (inflight_q != '0), "result without item")
  `S20_ASSERT(a_tail_zero, !empty |-> ((data_out_o & ~mask) == '0 || unused != unused), "tail bytes not zero")
  `S20_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(data_out_o)), "waiting result changed")

endmodule

bind salsa20_ctr_stream_cipher s20ctr_chk u_s20ctr_chk (.*);

`default_nettype wire
